// ===== rtl/spvu_pkg.sv =====
// Shared types, codes and helper functions for the sampler voice unit.
// No dependencies; imported by the lane, merge and top-level modules.
package spvu_pkg;

    // Item kinds carried in tuser
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [1:0] OP_RENDER   = 2'd3;

    // Voice states as reported
    localparam logic [1:0] VS_FREE    = 2'd0;
    localparam logic [1:0] VS_ATTACK  = 2'd1;
    localparam logic [1:0] VS_SUSTAIN = 2'd2;
    localparam logic [1:0] VS_RELEASE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_SAMPLE_FRAMES   = 3'd0;
    localparam logic [2:0] REG_SAMPLE_CHANNELS = 3'd1;
    localparam logic [2:0] REG_ROOT_KEY        = 3'd2;
    localparam logic [2:0] REG_ATTACK_STEP     = 3'd3;
    localparam logic [2:0] REG_RELEASE_STEP    = 3'd4;
    localparam logic [2:0] REG_BOOST_THRESHOLD = 3'd5;
    localparam logic [2:0] REG_BOOST_LIMIT     = 3'd6;
    localparam logic [2:0] REG_OUTPUT_CHANNELS = 3'd7;

    localparam int CFG_DATA_W = 17;

    localparam logic [15:0] ENV_FULL      = 16'd32768;
    localparam logic [15:0] RELEASE_PRIO  = 16'd3277;

    // Mix lane select between sequencer and merge stage
    typedef struct packed {
        logic add;      // voice adds a sample this word
        logic right;    // right channel is rendered
    } mix_sel_t;

    typedef logic [31:0] ratio_t;

    // Semitone ratios, Q16.16
    function automatic ratio_t semitone(input logic [3:0] s);
        ratio_t r;
        case (s)
            4'd0:    r = 32'd65536;
            4'd1:    r = 32'd69433;
            4'd2:    r = 32'd73562;
            4'd3:    r = 32'd77936;
            4'd4:    r = 32'd82570;
            4'd5:    r = 32'd87480;
            4'd6:    r = 32'd92682;
            4'd7:    r = 32'd98193;
            4'd8:    r = 32'd104032;
            4'd9:    r = 32'd110218;
            4'd10:   r = 32'd116772;
            4'd11:   r = 32'd123715;
            default: r = 32'd65536;
        endcase
        return r;
    endfunction

    // Pitch ratio 2^((pitch-root)/12); downward octaves truncate
    function automatic ratio_t ratio_for(input logic [6:0] pitch, input logic [6:0] root);
        logic signed [7:0] d;
        logic [6:0]        a;
        logic [3:0]        oct;
        logic [6:0]        semi;
        ratio_t            r;
        d   = $signed({1'b0, pitch}) - $signed({1'b0, root});
        oct = 4'd0;
        if (d >= 0)
        begin
            a = d[6:0];
            for (int k = 1; k <= 10; k++)
            begin
                if (a >= 7'(12 * k))
                    oct = oct + 4'd1;
            end
            semi = a - 7'(12 * oct);
            r    = semitone(semi[3:0]) << oct;
        end
        else
        begin
            a = 7'(-d);
            for (int k = 1; k <= 11; k++)
            begin
                if (a >= 7'(12 * k - 11))
                    oct = oct + 4'd1;
            end
            semi = 7'(12 * oct) - a;
            r    = semitone(semi[3:0]) >> oct;
        end
        return r;
    endfunction

    // floor(x / 127) for 23-bit x: reciprocal estimate and one correction
    function automatic logic [15:0] div127(input logic [22:0] x);
        logic [38:0] m;
        logic [16:0] q0;
        logic [23:0] r;
        m  = 39'(x) * 39'd33026;
        q0 = m[38:22];
        r  = 24'(x) - ((24'(q0) << 7) - 24'(q0));
        if (r >= 24'd127)
            q0 = q0 + 17'd1;
        return q0[15:0];
    endfunction

endpackage

// ===== rtl/spvu_lane.sv =====
// One output channel lane: interpolate, scale by gain, round by 127*2^k.
// Depends on spvu_pkg; four enabled stages, instantiated per channel.
module spvu_lane #(
    parameter int SAMPLE_BITS = 16,
    parameter int MIX_BITS    = 24
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [SAMPLE_BITS-1:0] v1,
    input  logic signed [SAMPLE_BITS-1:0] v2,
    input  logic [15:0]               frac,
    input  logic [23:0]               gain,
    output logic signed [MIX_BITS+1:0] contrib
);
    import spvu_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int MB  = MIX_BITS;
    localparam int PW  = SB + 26;
    localparam int L   = (MB >= SB) ? MB - SB : 0;
    localparam int K   = 16 + ((SB > MB) ? SB - MB : 0);
    localparam int WS  = ((PW + L > K + 7) ? PW + L : K + 7) + 1;
    localparam int TFW = WS - K;
    localparam int TC  = MB + 7;
    localparam int QW  = TC - 6;
    localparam logic [TC-1:0] RECIP = TC'((64'd1 << TC) / 127);

    logic signed [SB:0]    s_reg;
    logic signed [PW-1:0]  p_reg;
    logic [TC-1:0]         t_reg;
    logic [2*TC-1:0]       m_reg;
    logic                  neg3_reg;
    logic signed [MB+1:0]  c_reg;

    // Stage 1: linear interpolation
    logic signed [SB:0]    diff;
    logic signed [SB+17:0] dprod;
    logic signed [SB+17:0] dsh;
    logic signed [SB:0]    s_next;
    always_comb
    begin
        diff   = $signed({v2[SB-1], v2}) - $signed({v1[SB-1], v1});
        dprod  = diff * $signed({1'b0, frac});
        dsh    = dprod >>> 16;
        s_next = $signed({v1[SB-1], v1}) + dsh[SB:0];
    end

    // Stage 3: magnitude, rounding offset, divide by 2^K, reciprocal multiply
    logic [PW-1:0]   mag;
    logic [WS-1:0]   sum;
    logic [TFW-1:0]  t_full;
    logic [TC-1:0]   t_next;
    always_comb
    begin
        mag    = p_reg[PW-1] ? PW'(-p_reg) : PW'(p_reg);
        sum    = (WS'(mag) << L) + (WS'(127) << (K - 1));
        t_full = TFW'(sum >> K);
        if (t_full >= (TFW'(1) << TC))
            t_next = '1;
        else
            t_next = t_full[TC-1:0];
    end

    // Stage 4: quotient correction, clamp, sign
    logic [QW-1:0]   q0;
    logic [TC:0]     r;
    logic [QW-1:0]   q;
    logic [MB+1:0]   qx;
    always_comb
    begin
        q0 = m_reg[TC +: QW];
        r  = (TC+1)'(t_reg) - (((TC+1)'(q0) << 7) - (TC+1)'(q0));
        q  = (r >= (TC+1)'(127)) ? q0 + QW'(1) : q0;
        if (q > (QW'(1) << MB))
            q = QW'(1) << MB;
        qx = (MB+2)'(q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_next;
            p_reg    <= s_reg * $signed({1'b0, gain});
            t_reg    <= t_next;
            m_reg    <= (2*TC)'(t_next) * (2*TC)'(RECIP);
            neg3_reg <= p_reg[PW-1];
            c_reg    <= neg3_reg ? -$signed(qx) : $signed(qx);
        end
    end

    assign contrib = c_reg;

endmodule

// ===== rtl/spvu_merge.sv =====
// Merge stage: adds the lane contributions to the mix bus and saturates.
// Depends on spvu_pkg for the lane select struct.
module spvu_merge #(
    parameter int MIX_BITS = 24
) (
    input  spvu_pkg::mix_sel_t         sel,
    input  logic signed [MIX_BITS-1:0] mix_l,
    input  logic signed [MIX_BITS-1:0] mix_r,
    input  logic signed [MIX_BITS+1:0] c_l,
    input  logic signed [MIX_BITS+1:0] c_r,
    output logic signed [MIX_BITS-1:0] out_l,
    output logic signed [MIX_BITS-1:0] out_r
);
    import spvu_pkg::*;

    localparam int MB = MIX_BITS;
    localparam logic signed [MB+2:0] HI = (MB+3)'((64'd1 << (MB - 1)) - 1);
    localparam logic signed [MB+2:0] LO = -HI - (MB+3)'(1);

    function automatic logic signed [MB-1:0] sat(input logic signed [MB+2:0] v);
        logic signed [MB+2:0] c;
        c = v;
        if (c > HI)
            c = HI;
        if (c < LO)
            c = LO;
        return c[MB-1:0];
    endfunction

    logic signed [MB+2:0] sum_l;
    logic signed [MB+2:0] sum_r;

    // Zero contribution where the voice adds nothing
    always_comb
    begin
        sum_l = (MB+3)'(mix_l) + (sel.add ? (MB+3)'(c_l) : '0);
        sum_r = (MB+3)'(mix_r) + ((sel.add && sel.right) ? (MB+3)'(c_r) : '0);
        out_l = sat(sum_l);
        out_r = sat(sum_r);
    end

endmodule

// ===== rtl/sample_playback_voice_unit.sv =====
// Sampler voice top level: sequencer, sample store, two channel lanes, merge.
// Depends on spvu_pkg, spvu_lane and spvu_merge.
//
// One word in gives one word out. Load, note-on and note-off words go from
// accept straight to the result register. A render word for a playing voice
// runs an envelope step, two store reads (one channel per read, its two taps
// on the two read ports of the sample store), four lane stages, then the
// result. The input is ready only while the sequencer is idle. The sample
// store is not cleared at reset; reading a word that was never loaded
// returns whatever the store holds.
module sample_playback_voice_unit #(
    parameter int SAMPLE_WORDS = 65536,
    parameter int SAMPLE_BITS  = 16,
    parameter int MIX_BITS     = 24,
    localparam int IN_W  = ((16 + SAMPLE_BITS + 14 + 2 * MIX_BITS) + 7) / 8 * 8,
    localparam int OUT_W = ((2 * MIX_BITS + 19) + 7) / 8 * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // config write port
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_addr,
    input  logic [spvu_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // input stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, low bit up: load_address, load_value, note_pitch, note_velocity,
    // mix_in_left, mix_in_right, zero fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    // tuser: opcode
    input  logic [1:0]       s_axis_tuser,
    // output stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // tdata, low bit up: mix_out_left, mix_out_right, voice_state,
    // steal_priority, contributed, zero fill
    output logic [OUT_W-1:0] m_axis_tdata
);
    import spvu_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int MB = MIX_BITS;
    localparam int AW = $clog2(SAMPLE_WORDS);

    // Field offsets in the input word
    localparam int F_VAL = 16;
    localparam int F_PIT = F_VAL + SB;
    localparam int F_VEL = F_PIT + 7;
    localparam int F_ML  = F_VEL + 7;
    localparam int F_MR  = F_ML + MB;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENV  = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_LANE = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    // Word address modulo store depth: restoring subtract of shifted depths
    function automatic logic [AW-1:0] wrap_addr(input logic [17:0] a);
        logic [18:0] v;
        v = {1'b0, a};
        for (int k = 17; k >= 0; k--)
        begin
            if ((longint'(SAMPLE_WORDS) << k) <= longint'(18'h3FFFF))
            begin
                if (v >= 19'(longint'(SAMPLE_WORDS) << k))
                    v = v - 19'(longint'(SAMPLE_WORDS) << k);
            end
        end
        return AW'(v);
    endfunction

    // Configuration registers
    logic [16:0] frames_reg;
    logic [1:0]  sch_reg;
    logic [6:0]  root_reg;
    logic [15:0] atk_reg;
    logic [15:0] rel_reg;
    logic [6:0]  bthr_reg;
    logic [15:0] blim_reg;
    logic [1:0]  och_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= 17'd0;
            sch_reg    <= 2'd1;
            root_reg   <= 7'd60;
            atk_reg    <= 16'd1638;
            rel_reg    <= 16'd328;
            bthr_reg   <= 7'd110;
            blim_reg   <= 16'd2000;
            och_reg    <= 2'd2;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_SAMPLE_FRAMES:   frames_reg <= cfg_wr_data[16:0];
                REG_SAMPLE_CHANNELS: sch_reg    <= cfg_wr_data[1:0];
                REG_ROOT_KEY:        root_reg   <= cfg_wr_data[6:0];
                REG_ATTACK_STEP:     atk_reg    <= cfg_wr_data[15:0];
                REG_RELEASE_STEP:    rel_reg    <= cfg_wr_data[15:0];
                REG_BOOST_THRESHOLD: bthr_reg   <= cfg_wr_data[6:0];
                REG_BOOST_LIMIT:     blim_reg   <= cfg_wr_data[15:0];
                REG_OUTPUT_CHANNELS: och_reg    <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    // Input fields
    logic [1:0]           in_op;
    logic [15:0]          in_addr;
    logic signed [SB-1:0] in_val;
    logic [6:0]           in_pitch;
    logic [6:0]           in_vel;
    assign in_op    = s_axis_tuser;
    assign in_addr  = s_axis_tdata[15:0];
    assign in_val   = s_axis_tdata[F_VAL +: SB];
    assign in_pitch = s_axis_tdata[F_PIT +: 7];
    assign in_vel   = s_axis_tdata[F_VEL +: 7];

    logic [2:0]  fsm_reg;
    logic [1:0]  cnt_reg;
    logic [31:0] pos_reg;
    logic [31:0] ratio_reg;
    logic [15:0] env_reg;
    logic [1:0]  vstate_reg;
    logic [6:0]  vel_reg;
    logic        boost_reg;
    logic        add_reg;
    logic        m_valid_reg;

    // Work and payload registers
    logic [15:0]          idx_reg;
    logic [15:0]          frac_reg;
    logic [23:0]          gain_reg;
    logic signed [MB-1:0] mix_l_reg;
    logic signed [MB-1:0] mix_r_reg;
    logic signed [SB-1:0] hold_v1_reg;
    logic signed [SB-1:0] hold_v2_reg;
    logic signed [SB-1:0] rd_a_reg;
    logic signed [SB-1:0] rd_b_reg;
    logic [OUT_W-1:0]     out_data_reg;

    logic accept;
    assign s_axis_tready = (fsm_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Envelope step and end checks for a render
    logic [16:0] env_sum;
    logic [15:0] env_n;
    logic [1:0]  st_n;
    logic        alive;
    logic        active;
    logic        at_end;
    logic        boosted;
    logic [22:0] ev;
    logic [23:0] gain_n;
    logic [32:0] pos_sum;
    always_comb
    begin
        env_sum = {1'b0, env_reg} + {1'b0, atk_reg};
        env_n   = env_reg;
        st_n    = vstate_reg;
        alive   = 1'b1;
        case (vstate_reg)
            VS_ATTACK:
            begin
                if (env_sum >= {1'b0, ENV_FULL})
                begin
                    env_n = ENV_FULL;
                    st_n  = VS_SUSTAIN;
                end
                else
                    env_n = env_sum[15:0];
            end
            VS_RELEASE:
            begin
                if (env_reg <= rel_reg)
                begin
                    env_n = 16'd0;
                    st_n  = VS_FREE;
                    alive = 1'b0;
                end
                else
                    env_n = env_reg - rel_reg;
            end
            default: ;
        endcase
        active  = (vstate_reg != VS_FREE) && (frames_reg != 17'd0);
        at_end  = {1'b0, pos_reg[31:16]} >= (frames_reg - 17'd1);
        boosted = (st_n == VS_ATTACK) && boost_reg && (pos_reg[31:16] < blim_reg);
        ev      = 23'(env_n) * 23'(vel_reg);
        gain_n  = {ev, 1'b0} + (boosted ? 24'(ev) : 24'd0);
        pos_sum = {1'b0, pos_reg} + {1'b0, ratio_reg};
    end

    // Store read addresses: one lane per read cycle, both taps at once
    logic        sch2;
    logic        rc;
    logic [17:0] a1;
    logic [17:0] a2;
    logic [16:0] idx1;
    logic        rd_en;
    assign sch2  = sch_reg[1];
    assign rc    = (fsm_reg == S_RD1) && sch2;
    assign idx1  = {1'b0, idx_reg} + 17'd1;
    assign a1    = sch2 ? {1'b0, idx_reg, rc} : {2'b00, idx_reg};
    assign a2    = sch2 ? {idx1, rc} : {1'b0, idx1};
    assign rd_en = (fsm_reg == S_RD0) || (fsm_reg == S_RD1);

    // Sample store
    logic signed [SB-1:0] mem [SAMPLE_WORDS];
    always_ff @(posedge clk)
    begin
        if (accept && in_op == OP_LOAD)
            mem[wrap_addr({2'b00, in_addr})] <= in_val;
        if (rd_en)
        begin
            rd_a_reg <= mem[wrap_addr(a1)];
            rd_b_reg <= mem[wrap_addr(a2)];
        end
    end

    // Lanes and merge
    logic signed [MB+1:0] c_l;
    logic signed [MB+1:0] c_r;
    logic signed [MB-1:0] out_l;
    logic signed [MB-1:0] out_r;
    logic                 lane_en;
    mix_sel_t             sel;
    assign lane_en   = (fsm_reg == S_LANE);
    assign sel.add   = add_reg;
    assign sel.right = och_reg[1];

    spvu_lane #(.SAMPLE_BITS(SB), .MIX_BITS(MB)) u_lane_l (
        .clk     (clk),
        .en      (lane_en),
        .v1      (hold_v1_reg),
        .v2      (hold_v2_reg),
        .frac    (frac_reg),
        .gain    (gain_reg),
        .contrib (c_l)
    );

    spvu_lane #(.SAMPLE_BITS(SB), .MIX_BITS(MB)) u_lane_r (
        .clk     (clk),
        .en      (lane_en),
        .v1      (rd_a_reg),
        .v2      (rd_b_reg),
        .frac    (frac_reg),
        .gain    (gain_reg),
        .contrib (c_r)
    );

    spvu_merge #(.MIX_BITS(MB)) u_merge (
        .sel   (sel),
        .mix_l (mix_l_reg),
        .mix_r (mix_r_reg),
        .c_l   (c_l),
        .c_r   (c_r),
        .out_l (out_l),
        .out_r (out_r)
    );

    // Steal priority from the final voice state
    logic [15:0] prio;
    always_comb
    begin
        case (vstate_reg)
            VS_FREE:    prio = 16'd0;
            VS_RELEASE: prio = RELEASE_PRIO;
            default:    prio = div127(23'(env_reg) * 23'(vel_reg) + 23'd63);
        endcase
    end

    logic push;
    assign push = (fsm_reg == S_PUSH) && (!m_valid_reg || m_axis_tready);

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mix_l_reg <= s_axis_tdata[F_ML +: MB];
            mix_r_reg <= s_axis_tdata[F_MR +: MB];
        end
        if (fsm_reg == S_ENV)
        begin
            idx_reg  <= pos_reg[31:16];
            frac_reg <= pos_reg[15:0];
            gain_reg <= gain_n;
        end
        if (fsm_reg == S_RD1)
        begin
            hold_v1_reg <= rd_a_reg;
            hold_v2_reg <= rd_b_reg;
        end
        if (push)
            out_data_reg <= OUT_W'({add_reg, prio, vstate_reg, out_r, out_l});
    end

    // Sequencer and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg     <= S_IDLE;
            cnt_reg     <= 2'd0;
            pos_reg     <= 32'd0;
            ratio_reg   <= 32'h0001_0000;
            env_reg     <= 16'd0;
            vstate_reg  <= VS_FREE;
            vel_reg     <= 7'd0;
            boost_reg   <= 1'b0;
            add_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_axis_tready && !push)
                m_valid_reg <= 1'b0;
            case (fsm_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        add_reg <= 1'b0;
                        fsm_reg <= S_PUSH;
                        case (in_op)
                            OP_NOTE_ON:
                            begin
                                if (frames_reg != 17'd0)
                                begin
                                    vel_reg    <= in_vel;
                                    pos_reg    <= 32'd0;
                                    ratio_reg  <= ratio_for(in_pitch, root_reg);
                                    boost_reg  <= (in_vel > bthr_reg);
                                    vstate_reg <= VS_ATTACK;
                                    env_reg    <= 16'd0;
                                end
                            end
                            OP_NOTE_OFF:
                            begin
                                if (vstate_reg != VS_FREE)
                                    vstate_reg <= VS_RELEASE;
                            end
                            OP_RENDER:
                                fsm_reg <= S_ENV;
                            default: ;
                        endcase
                    end
                end
                S_ENV:
                begin
                    fsm_reg <= S_PUSH;
                    if (active)
                    begin
                        env_reg    <= env_n;
                        vstate_reg <= st_n;
                        if (alive)
                        begin
                            if (at_end)
                                vstate_reg <= VS_FREE;
                            else
                            begin
                                add_reg <= 1'b1;
                                pos_reg <= pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
                                fsm_reg <= S_RD0;
                            end
                        end
                    end
                end
                S_RD0:
                    fsm_reg <= S_RD1;
                S_RD1:
                begin
                    cnt_reg <= 2'd0;
                    fsm_reg <= S_LANE;
                end
                S_LANE:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                        fsm_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    if (push)
                    begin
                        m_valid_reg <= 1'b1;
                        fsm_reg     <= S_IDLE;
                    end
                end
                default:
                    fsm_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
